FILE: hw/rtl/csc_pkg.sv
// shared types and constants for the clock skew compensator
package csc_pkg;

  localparam int CAPTURE_BITS = 16;

  localparam int TIMER_W = 63;
  localparam int CNT_W   = 21;
  localparam int CAP_W   = 16;
  localparam int RTC_W   = 37;
  localparam int HF_W    = 27;
  localparam int CW_W    = 21;
  localparam int AVG_W   = 29;
  localparam int RATE_W  = 32;
  localparam int DIFF_W  = 32;
  localparam int MUL_W   = 32;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // low bits of the timer that come from the capture unit
  localparam logic [TIMER_W-1:0] CAP_MASK = (TIMER_W'(1) << CAPTURE_BITS) - TIMER_W'(1);

  localparam logic [HF_W-1:0]   HF_RESET   = HF_W'(48000000);
  localparam logic [CW_W-1:0]   CW_RESET   = CW_W'(700);
  localparam logic [RATE_W-1:0] RATE_ONE   = 32'h4000_0000;
  localparam logic [RATE_W-1:0] RATE_SAT   = 32'hFFFF_FFFF;
  localparam logic [MUL_W-1:0]  DIV5_RECIP = 32'hCCCC_CCCD;
  localparam logic [42:0]       IDEAL_RND  = 43'd16384;
  localparam logic [61:0]       P_RND      = 62'h2000_0000;

  localparam int DIV_STEPS = 38;
  localparam int DIV_CNT_W = 6;

  localparam logic REG_HF_FREQ_HZ = 1'b0;
  localparam logic REG_CAL_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    CMD_CAL     = 2'd0,
    CMD_SYNC    = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MUL_AVG = 3'd0,
    MUL_NOM = 3'd1,
    MUL_CH  = 3'd2,
    MUL_CL  = 3'd3,
    MUL_DLO = 3'd4,
    MUL_DHI = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic     cap;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     avg_upd;
    logic     rate_sat;
    logic     div_init;
    logic     div_step;
    logic     ideal_lo;
    logic     ideal_add;
    logic     sync_upd;
    logic     base_calc;
    logic     sum_lo;
    logic     fin_p;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic avg_zero;
    logic sat;
    logic div_last;
    logic is_sync;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: hw/rtl/csc_regs.sv
// configuration registers behind the apb-style port
module csc_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [csc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [csc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic [csc_pkg::HF_W-1:0]       hf_freq_hz,
  output logic [csc_pkg::CW_W-1:0]       cal_window
);

  logic [csc_pkg::HF_W-1:0] hf_r, hf_nxt;
  logic [csc_pkg::CW_W-1:0] cw_r, cw_nxt;
  logic                     wr;
  logic                     idx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[2];

  always_comb begin
    hf_nxt = hf_r;
    cw_nxt = cw_r;
    if (wr) begin
      unique case (idx)
        csc_pkg::REG_HF_FREQ_HZ: hf_nxt = cfg_pwdata[csc_pkg::HF_W-1:0];
        csc_pkg::REG_CAL_WINDOW: cw_nxt = cfg_pwdata[csc_pkg::CW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      csc_pkg::REG_HF_FREQ_HZ: cfg_prdata = csc_pkg::CFG_DATA_W'(hf_r);
      csc_pkg::REG_CAL_WINDOW: cfg_prdata = csc_pkg::CFG_DATA_W'(cw_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hf_r <= csc_pkg::HF_RESET;
      cw_r <= csc_pkg::CW_RESET;
    end else begin
      hf_r <= hf_nxt;
      cw_r <= cw_nxt;
    end
  end

  assign hf_freq_hz = hf_r;
  assign cal_window = cw_r;

endmodule

FILE: hw/rtl/csc_ctrl.sv
// sequencing state machine for the compensator
module csc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_tuser,
  input  csc_pkg::ctrl_sts_t sts,
  output csc_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_CAL_MUL  = 14'b00000000000010,
    ST_CAL_UPD  = 14'b00000000000100,
    ST_NOM_MUL  = 14'b00000000001000,
    ST_NOM_CHK  = 14'b00000000010000,
    ST_DIV      = 14'b00000000100000,
    ST_IDL_CH   = 14'b00000001000000,
    ST_IDL_CL   = 14'b00000010000000,
    ST_IDL_ADD  = 14'b00000100000000,
    ST_SYNC_UPD = 14'b00001000000000,
    ST_MEA_DLO  = 14'b00010000000000,
    ST_MEA_DHI  = 14'b00100000000000,
    ST_MEA_P    = 14'b01000000000000,
    ST_MEA_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = csc_pkg::MUL_AVG;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          unique case (csc_pkg::cmd_t'(in_tuser))
            csc_pkg::CMD_CAL:     state_nxt = ST_CAL_MUL;
            csc_pkg::CMD_SYNC:    state_nxt = ST_IDL_CH;
            csc_pkg::CMD_MEASURE: state_nxt = ST_IDL_CH;
            csc_pkg::CMD_NONE:    state_nxt = ST_IDLE;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CAL_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = csc_pkg::MUL_AVG;
        state_nxt   = ST_CAL_UPD;
      end
      ST_CAL_UPD: begin
        cmd.avg_upd = 1'b1;
        state_nxt   = ST_NOM_MUL;
      end
      ST_NOM_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = csc_pkg::MUL_NOM;
        state_nxt   = ST_NOM_CHK;
      end
      ST_NOM_CHK: begin
        priority if (sts.avg_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.sat) begin
          cmd.rate_sat = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDL_CH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = csc_pkg::MUL_CH;
        state_nxt   = ST_IDL_CL;
      end
      ST_IDL_CL: begin
        cmd.ideal_lo = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = csc_pkg::MUL_CL;
        state_nxt    = ST_IDL_ADD;
      end
      ST_IDL_ADD: begin
        cmd.ideal_add = 1'b1;
        state_nxt     = sts.is_sync ? ST_SYNC_UPD : ST_MEA_DLO;
      end
      ST_SYNC_UPD: begin
        cmd.sync_upd = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_MEA_DLO: begin
        cmd.base_calc = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = csc_pkg::MUL_DLO;
        state_nxt     = ST_MEA_DHI;
      end
      ST_MEA_DHI: begin
        cmd.sum_lo  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = csc_pkg::MUL_DHI;
        state_nxt   = ST_MEA_P;
      end
      ST_MEA_P: begin
        cmd.fin_p = 1'b1;
        state_nxt = ST_MEA_OUT;
      end
      ST_MEA_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/csc_dp.sv
// datapath: item latch, shared multiplier, serial divider, timing state, output register
module csc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [csc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [csc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [csc_pkg::HF_W-1:0]       hf_freq_hz,
  input  logic [csc_pkg::CW_W-1:0]       cal_window,
  input  csc_pkg::ctrl_cmd_t             cmd,
  output csc_pkg::ctrl_sts_t             sts
);

  // unpacked input fields
  logic [csc_pkg::CNT_W-1:0]   f_cnt;
  logic [csc_pkg::TIMER_W-1:0] f_timer;
  logic [csc_pkg::CAP_W-1:0]   f_cap;
  logic [csc_pkg::RTC_W-1:0]   f_rtc;
  logic [csc_pkg::TIMER_W-1:0] merged;

  assign f_cnt   = in_tdata[20:0];
  assign f_timer = in_tdata[83:21];
  assign f_cap   = in_tdata[99:84];
  assign f_rtc   = in_tdata[136:100];
  assign merged  = (f_timer & ~csc_pkg::CAP_MASK)
                 | (csc_pkg::TIMER_W'(f_cap) & csc_pkg::CAP_MASK);

  // latched item
  logic [csc_pkg::CNT_W-1:0]   cnt_r;
  logic [csc_pkg::TIMER_W-1:0] merged_r;
  logic [csc_pkg::RTC_W-1:0]   rtc_r;
  logic                        is_sync_r;

  // architectural state
  logic [csc_pkg::AVG_W-1:0]   avg_r, avg_nxt;
  logic                        have_r, have_nxt;
  logic [csc_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic [csc_pkg::TIMER_W-1:0] sync_r, sync_nxt;
  logic [31:0]                 offset_r, offset_nxt;

  // working registers
  logic [2*csc_pkg::MUL_W-1:0] prod_r;
  logic [csc_pkg::AVG_W-1:0]   rem_r;
  logic [csc_pkg::RATE_W-1:0]  quo_r;
  logic [csc_pkg::DIV_CNT_W-1:0] dcnt_r;
  logic [31:0]                 acc_r;
  logic [61:0]                 d_r;
  logic [31:0]                 base_r;
  logic [61:0]                 lo_r;
  logic [31:0]                 p_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [csc_pkg::DIFF_W-1:0]  out_data_r;

  // multiplier operand select
  logic [csc_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [csc_pkg::MUL_W-1:0] avg_sum;

  assign avg_sum = {avg_r, 2'b00} + {3'b000, cnt_r, 8'h00} + 32'd2;

  always_comb begin
    unique case (cmd.mul_sel)
      csc_pkg::MUL_AVG: begin
        mul_a = avg_sum;
        mul_b = csc_pkg::DIV5_RECIP;
      end
      csc_pkg::MUL_NOM: begin
        mul_a = csc_pkg::MUL_W'(cal_window);
        mul_b = csc_pkg::MUL_W'(hf_freq_hz);
      end
      csc_pkg::MUL_CH: begin
        mul_a = csc_pkg::MUL_W'(rtc_r[36:15]);
        mul_b = csc_pkg::MUL_W'(hf_freq_hz);
      end
      csc_pkg::MUL_CL: begin
        mul_a = csc_pkg::MUL_W'(rtc_r[14:0]);
        mul_b = csc_pkg::MUL_W'(hf_freq_hz);
      end
      csc_pkg::MUL_DLO: begin
        mul_a = d_r[31:0];
        mul_b = rate_r;
      end
      csc_pkg::MUL_DHI: begin
        mul_a = csc_pkg::MUL_W'(d_r[61:32]);
        mul_b = rate_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // calibration arithmetic
  logic [32:0] nominal;
  logic [29:0] rem_sh;
  logic        rem_ge;
  logic [29:0] rem_sub;
  logic [42:0] frac_sum;
  logic [61:0] p_sum;

  assign nominal  = prod_r[47:15];
  assign rem_sh   = {rem_r, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, avg_r};
  assign rem_sub  = rem_sh - {1'b0, avg_r};
  assign frac_sum = {1'b0, prod_r[41:0]} + (is_sync_r ? csc_pkg::IDEAL_RND : 43'd0);
  assign p_sum    = lo_r + {prod_r[29:0], 32'd0} + csc_pkg::P_RND;

  assign sts.avg_zero = (avg_r == '0);
  assign sts.sat      = {nominal, 6'd0} >= {10'd0, avg_r};
  assign sts.div_last = (dcnt_r == csc_pkg::DIV_CNT_W'(csc_pkg::DIV_STEPS - 1));
  assign sts.is_sync  = is_sync_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    avg_nxt    = avg_r;
    have_nxt   = have_r;
    rate_nxt   = rate_r;
    sync_nxt   = sync_r;
    offset_nxt = offset_r;
    if (cmd.avg_upd) begin
      avg_nxt  = have_r ? prod_r[62:34] : {cnt_r, 8'h00};
      have_nxt = 1'b1;
    end
    if (cmd.rate_sat) begin
      rate_nxt = csc_pkg::RATE_SAT;
    end
    if (cmd.div_step && sts.div_last) begin
      rate_nxt = {quo_r[30:0], rem_ge};
    end
    if (cmd.sync_upd) begin
      sync_nxt   = merged_r;
      offset_nxt = merged_r[31:0] - acc_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r       <= '0;
      have_r      <= 1'b0;
      rate_r      <= csc_pkg::RATE_ONE;
      sync_r      <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      avg_r       <= avg_nxt;
      have_r      <= have_nxt;
      rate_r      <= rate_nxt;
      sync_r      <= sync_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cnt_r     <= f_cnt;
      merged_r  <= merged;
      rtc_r     <= f_rtc;
      is_sync_r <= (csc_pkg::cmd_t'(in_tuser) == csc_pkg::CMD_SYNC);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.div_init) begin
      rem_r  <= nominal[csc_pkg::AVG_W-1:0];
      quo_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sub[csc_pkg::AVG_W-1:0] : rem_sh[csc_pkg::AVG_W-1:0];
      quo_r  <= {quo_r[30:0], rem_ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.ideal_lo) begin
      acc_r <= prod_r[31:0];
      d_r   <= 62'(merged_r - sync_r);
    end else if (cmd.ideal_add) begin
      acc_r <= acc_r + {4'h0, frac_sum[42:15]};
    end
    if (cmd.base_calc) begin
      base_r <= sync_r[31:0] - offset_r - acc_r;
    end
    if (cmd.sum_lo) begin
      lo_r <= prod_r[61:0];
    end
    if (cmd.fin_p) begin
      p_r <= p_sum[61:30];
    end
    if (cmd.load_out) begin
      out_data_r <= base_r + p_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/clock_skew_compensator_core.sv
// top level of the clock skew compensator
// A transfer is accepted only in the idle state. A calibration transfer runs smoothing and
// the nominal-count product on one shared 32x32 multiplier, then a restoring divider
// produces the rate one quotient bit per cycle; when the average is zero or the rate
// saturates the divider is skipped. A sync transfer and a measure transfer step through the
// same shared multiplier, and a measure can also wait for the output register to free up; an
// unused command code is accepted and dropped. The result of a measure waits in an output
// register, so the next transfer is accepted while it is held.
module clock_skew_compensator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cal_count[20:0], timer_value[83:21], capture[99:84], rtc_value[136:100], zero fill
  input  logic [csc_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // difference[31:0]
  output logic [csc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [csc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [csc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  logic [csc_pkg::HF_W-1:0] hf_freq_hz;
  logic [csc_pkg::CW_W-1:0] cal_window;
  csc_pkg::ctrl_cmd_t       cmd;
  csc_pkg::ctrl_sts_t       sts;

  csc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .hf_freq_hz  (hf_freq_hz),
    .cal_window  (cal_window)
  );

  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  csc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .hf_freq_hz (hf_freq_hz),
    .cal_window (cal_window),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: dv/clock_skew_compensator_core_tb.sv
// self-checking testbench for the clock skew compensator core
module clock_skew_compensator_core_tb;
  import csc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 200;

  typedef struct {
    cmd_t               cmd;
    logic [CNT_W-1:0]   cnt;
    logic [TIMER_W-1:0] tv;
    logic [CAP_W-1:0]   cap;
    logic [RTC_W-1:0]   rtc;
  } capture_req_t;

  class skew_tracker;
    logic [HF_W-1:0]   hf;
    logic [CW_W-1:0]   cw;
    logic [AVG_W-1:0]  avg;
    logic              have_sample;
    logic [RATE_W-1:0] rate;
    logic [63:0]       sync_point;
    logic [31:0]       offset;
    logic [DIFF_W-1:0] expected_diffs[$];
    int                errors;
    int                accepted;
    int                checked;

    function new();
      hf          = HF_RESET;
      cw          = CW_RESET;
      avg         = '0;
      have_sample = 1'b0;
      rate        = RATE_ONE;
      sync_point  = '0;
      offset      = '0;
      errors      = 0;
      accepted    = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_HF_FREQ_HZ: hf = value[HF_W-1:0];
        REG_CAL_WINDOW: cw = value[CW_W-1:0];
        default: ;
      endcase
    endfunction

    // floor((c * hf + rnd) / 32768), modulo 2^64
    function logic [63:0] ideal_ticks(logic [RTC_W-1:0] c, logic [63:0] rnd);
      return 64'(c >> 15) * 64'(hf) + ((64'(c[14:0]) * 64'(hf) + rnd) >> 15);
    endfunction

    function void note_item(capture_req_t it);
      logic [63:0] merged;
      logic [63:0] sample;
      logic [63:0] nominal;
      logic [63:0] d;
      logic [63:0] p;
      logic [63:0] off64;
      logic [63:0] res;
      accepted++;
      merged = 64'((it.tv & ~CAP_MASK) | (TIMER_W'(it.cap) & CAP_MASK));
      case (it.cmd)
        CMD_CAL: begin
          sample = 64'(it.cnt) << 8;
          if (!have_sample) begin
            have_sample = 1'b1;
            avg = AVG_W'(sample);
          end else begin
            avg = AVG_W'((64'(avg) * 4 + sample + 64'd2) / 64'd5);
          end
          nominal = (64'(cw) * 64'(hf)) >> 15;
          if (avg != '0) begin
            if ((nominal << 6) >= 64'(avg)) rate = RATE_SAT;
            else rate = RATE_W'((nominal << 38) / 64'(avg));
          end
        end
        CMD_SYNC: begin
          sync_point = merged;
          offset = 32'(merged - ideal_ticks(it.rtc, 64'(IDEAL_RND)));
        end
        CMD_MEASURE: begin
          d = merged - sync_point;
          p = (d * 64'(rate) + 64'(P_RND)) >> 30;
          off64 = {{32{offset[31]}}, offset};
          res = sync_point - off64 + p - ideal_ticks(it.rtc, 64'd0);
          expected_diffs.push_back(res[DIFF_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_difference(logic [DIFF_W-1:0] got);
      logic [DIFF_W-1:0] want;
      if (expected_diffs.size() == 0) begin
        $error("difference: unexpected result, actual %0d", $signed(got));
        errors++;
      end else begin
        want = expected_diffs.pop_front();
        checked++;
        if (got !== want) begin
          $error("difference mismatch: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  skew_tracker tracker;
  int          cycle_count   = 0;
  int          in_gap_pct    = 20;
  int          out_stall_pct = 20;
  int          settings      = 1;

  clock_skew_compensator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_difference(out_tdata);
  end

  initial begin
    forever begin
      if ($urandom_range(0, 99) < out_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic capture_req_t make_item(cmd_t cmd, logic [CNT_W-1:0] cnt,
                                             logic [TIMER_W-1:0] tv, logic [CAP_W-1:0] cap,
                                             logic [RTC_W-1:0] rtc);
    capture_req_t it;
    it.cmd = cmd;
    it.cnt = cnt;
    it.tv  = tv;
    it.cap = cap;
    it.rtc = rtc;
    return it;
  endfunction

  task automatic send_item(capture_req_t it);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= IN_DATA_W'({it.rtc, it.cap, it.tv, it.cnt});
    do @(posedge clk); while (!in_tready);
    tracker.note_item(it);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // let outstanding differences drain and the block finish any calibration
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.expected_diffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [HF_W-1:0] hf, logic [CW_W-1:0] cw, int n,
                           int in_pct, int out_pct);
    capture_req_t it;
    logic [63:0]  rtc_now;
    logic [63:0]  timer_now;
    logic [63:0]  nominal;
    logic [63:0]  step;
    longint       c;
    longint       j;
    int           skew;
    int           pick;
    settle();
    write_reg(REG_HF_FREQ_HZ, CFG_DATA_W'(hf));
    write_reg(REG_CAL_WINDOW, CFG_DATA_W'(cw));
    settings++;
    in_gap_pct    = in_pct;
    out_stall_pct = out_pct;
    rtc_now   = {$urandom, $urandom};
    timer_now = {$urandom, $urandom};
    skew      = $urandom_range(0, 3);
    nominal   = (64'(cw) * 64'(hf)) >> 15;
    repeat (n) begin
      if ($urandom_range(0, 99) < 25) begin
        it.cmd = cmd_t'($urandom_range(0, 3));
        it.cnt = CNT_W'($urandom);
        it.tv  = TIMER_W'({$urandom, $urandom});
        it.cap = CAP_W'($urandom);
        it.rtc = RTC_W'({$urandom, $urandom});
      end else begin
        step = $urandom_range(1, 4096);
        rtc_now   += step;
        timer_now += ((step * 64'(hf)) >> 15) + step * 64'(skew);
        pick = $urandom_range(0, 99);
        it.cmd = (pick < 25) ? CMD_CAL : ((pick < 45) ? CMD_SYNC : CMD_MEASURE);
        it.tv  = TIMER_W'(timer_now + 64'($urandom_range(0, 2000)));
        it.cap = CAP_W'(timer_now);
        it.rtc = RTC_W'(rtc_now);
        if (nominal > 64'((1 << CNT_W) - 1)) begin
          it.cnt = CNT_W'($urandom);
        end else begin
          j = longint'(nominal / 1000) + 2;
          c = longint'(nominal) + longint'($urandom_range(0, int'(2 * j))) - j;
          if (c < 0) c = 0;
          if (c > (1 << CNT_W) - 1) c = (1 << CNT_W) - 1;
          it.cnt = CNT_W'(c);
        end
      end
      send_item(it);
    end
  endtask

  initial begin
    tracker     = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_NONE;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // measure before sync, field extremes, ignored code, zero average, saturation
    send_item(make_item(CMD_MEASURE, '0, 63'h1234_5678_9abc_def0, 16'h0f0f, 37'd1000000));
    send_item(make_item(CMD_MEASURE, '1, '1, '1, '1));
    send_item(make_item(CMD_MEASURE, '0, '0, '0, '0));
    send_item(make_item(CMD_NONE, '1, '1, '1, '1));
    send_item(make_item(CMD_CAL, '0, '0, '0, '0));
    send_item(make_item(CMD_MEASURE, '0, 63'h1000_0000, '0, '0));
    send_item(make_item(CMD_CAL, 21'd1, '0, '0, '0));
    send_item(make_item(CMD_MEASURE, '0, 63'h7fff_0000_0000_0000, 16'h1234, 37'd5));
    send_item(make_item(CMD_CAL, '1, '0, '0, '0));
    repeat (3) send_item(make_item(CMD_CAL, 21'd1025390, '0, '0, '0));
    send_item(make_item(CMD_SYNC, '0, '1, '1, '1));
    send_item(make_item(CMD_MEASURE, '0, '1, '0, '1));
    send_item(make_item(CMD_SYNC, '0, '0, '0, '0));
    send_item(make_item(CMD_MEASURE, '0, '1, '1, '1));
    send_item(make_item(CMD_NONE, '0, '0, '0, '0));
    send_item(make_item(CMD_SYNC, '0, 63'd48000000, '0, 37'd32768));
    send_item(make_item(CMD_MEASURE, '0, 63'd96000100, '0, 37'd65536));
    send_item(make_item(CMD_MEASURE, '0, '0, '0, '0));
    send_item(make_item(CMD_CAL, 21'd1025390, '0, '0, '0));
    send_item(make_item(CMD_MEASURE, '0, 63'd144003000, 16'h55aa, 37'd98304));

    run_phase(27'd16000000, 21'd2048, PHASE_ITEMS, 30, 30);
    run_phase(27'd1, 21'd1, PHASE_ITEMS, 50, 10);
    run_phase(27'd100000000, 21'd1048576, PHASE_ITEMS, 10, 50);
    run_phase(27'd100000000, 21'd1, PHASE_ITEMS, 0, 30);
    run_phase(27'd1, 21'd1048576, PHASE_ITEMS, 30, 0);
    run_phase(27'($urandom_range(1, 100000000)), 21'($urandom_range(1, 1048576)),
              PHASE_ITEMS, 20, 20);
    run_phase(HF_RESET, CW_RESET, PHASE_ITEMS, 0, 0);
    settle();

    $display("sent %0d capture and calibration transfers across %0d rate settings",
             tracker.accepted, settings);
    $display("compared %0d measured differences, %0d mismatches",
             tracker.checked, tracker.errors);
    if (tracker.errors == 0 && tracker.expected_diffs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
